>>> hdl/halton_joint_seed_generator_macros.svh
// Assertion macros for the Halton joint seed generator.
// Included by the top level; no other dependencies.
`ifndef HALTON_JOINT_SEED_GENERATOR_MACROS_SVH
`define HALTON_JOINT_SEED_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HJSG_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define HJSG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/hjsg_pkg.sv
// Shared types, constants and tables for the Halton joint seed generator.
// No dependencies; used by hjsg_datapath and the top level.
`timescale 1ns / 1ps

package hjsg_pkg;

    localparam int START_INDEX_W  = 16;
    localparam int COUNT_W        = 4;
    localparam int ANGLE_W        = 15;
    localparam int BASE_W         = 6;
    localparam int BASE_SEL_W     = 4;
    localparam int FRAC_BITS      = 16;
    localparam int RECIP_SHIFT    = 32;
    localparam int RECIP_W        = 32;

    localparam int MAX_JOINTS_DEF = 8;
    localparam int INDEX_BITS_DEF = 16;

    localparam logic [COUNT_W-1:0]   JOINT_COUNT_RESET = 4'd6;
    localparam logic [RECIP_W-1:0]   TWO_PI_Q3_28      = 32'd1686629713;
    localparam logic [FRAC_BITS-1:0] HALF_Q0_16        = 16'h8000;

    // Datapath operations issued by the sequencer.
    typedef enum logic [2:0] {
        DP_IDLE,
        DP_LOAD,
        DP_MUL_DIGIT,
        DP_FIX,
        DP_ACC,
        DP_DIV_STEP,
        DP_MUL_ANGLE,
        DP_ROUND
    } dp_op_t;

    typedef struct packed {
        dp_op_t                  op;
        logic [BASE_SEL_W-1:0]   base_sel;
    } dp_ctrl_t;

    typedef struct packed {
        logic                        digits_done;
        logic signed [ANGLE_W-1:0]   angle;
    } dp_status_t;

    // j-th prime, the van der Corput base of joint j.
    function automatic logic [BASE_W-1:0] prime_base(input logic [BASE_SEL_W-1:0] sel);
        logic [BASE_W-1:0] b;
        case (sel)
            4'd0:    b = 6'd2;
            4'd1:    b = 6'd3;
            4'd2:    b = 6'd5;
            4'd3:    b = 6'd7;
            4'd4:    b = 6'd11;
            4'd5:    b = 6'd13;
            4'd6:    b = 6'd17;
            4'd7:    b = 6'd19;
            4'd8:    b = 6'd23;
            4'd9:    b = 6'd29;
            4'd10:   b = 6'd31;
            4'd11:   b = 6'd37;
            4'd12:   b = 6'd41;
            4'd13:   b = 6'd43;
            4'd14:   b = 6'd47;
            4'd15:   b = 6'd53;
            default: b = 6'd2;
        endcase
        return b;
    endfunction

    // floor(2^32 / base); quotient estimate is exact or one low.
    function automatic logic [RECIP_W-1:0] recip_q32(input logic [BASE_SEL_W-1:0] sel);
        logic [RECIP_W-1:0] r;
        case (sel)
            4'd0:    r = 32'd2147483648;
            4'd1:    r = 32'd1431655765;
            4'd2:    r = 32'd858993459;
            4'd3:    r = 32'd613566756;
            4'd4:    r = 32'd390451572;
            4'd5:    r = 32'd330382099;
            4'd6:    r = 32'd252645135;
            4'd7:    r = 32'd226050910;
            4'd8:    r = 32'd186737708;
            4'd9:    r = 32'd148102320;
            4'd10:   r = 32'd138547332;
            4'd11:   r = 32'd116080197;
            4'd12:   r = 32'd104755299;
            4'd13:   r = 32'd99882960;
            4'd14:   r = 32'd91382282;
            4'd15:   r = 32'd81037118;
            default: r = 32'd2147483648;
        endcase
        return r;
    endfunction

endpackage

>>> hdl/halton_joint_seed_generator.sv
// Halton joint seed generator: top level with sequencer, config register and result register.
// Depends on hjsg_pkg, hjsg_datapath and halton_joint_seed_generator_macros.svh.
`timescale 1ns / 1ps
`include "halton_joint_seed_generator_macros.svh"

// Usage
//   s_ channel: one transaction carries a start index. s_ready is high only while the
//   sequencer is idle; one index is worked on at a time.
//   m_ channel: one transaction per joint, joint_number counting from 0, m_last on the
//   final joint of the seed. A joint count of zero gives no transactions at all.
//   cfg channel: writes joint_count; always ready. Write only while the block is idle.
// Sequence
//   Per joint with a nonzero index: a load step, then for each base-b digit of the
//   index a multiply by reciprocal, a remainder step and a correct/accumulate step,
//   then the restoring fraction divider steps, the 2*pi scaling and rounding, and a
//   last step that hands the angle to the result register. Each seed also takes an
//   accept step in idle. A zero index skips the arithmetic and hands over angle 0.
//   The wide multiplier is shared by the digit and 2*pi steps.
// Reset and stall
//   aresetn (synchronous, low) returns to idle, drops m_valid and sets joint_count to 6.
//   A result waits in the output register while m_ready is low; the next joint keeps
//   computing and then holds until the register frees up. A new index is accepted
//   while the last result of the previous seed still waits.

module halton_joint_seed_generator #(
    parameter int MAX_JOINTS = hjsg_pkg::MAX_JOINTS_DEF,
    parameter int INDEX_BITS = hjsg_pkg::INDEX_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // configuration
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [hjsg_pkg::COUNT_W-1:0]           cfg_data,
    // start index in
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [hjsg_pkg::START_INDEX_W-1:0]     s_start_index,
    // angles out
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [((MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1)-1:0] m_joint_number,
    output logic signed [hjsg_pkg::ANGLE_W-1:0]    m_angle,
    output logic                                   m_last
);
    import hjsg_pkg::*;

    localparam int IW        = (INDEX_BITS < START_INDEX_W) ? INDEX_BITS : START_INDEX_W;
    localparam int JN_W      = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
    localparam int JC_W      = $clog2(MAX_JOINTS + 1);
    localparam int DIV_CNT_W = $clog2(FRAC_BITS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_JOINT,
        S_MUL,
        S_FIX,
        S_ACC,
        S_DIV,
        S_ANG_MUL,
        S_ANG_RND,
        S_EMIT
    } state_t;

    state_t                    state_reg, state_next;
    logic [COUNT_W-1:0]        joint_count_reg, joint_count_next;
    logic [JC_W-1:0]           joint_reg, joint_next;       // joint being computed
    logic [JC_W-1:0]           count_reg, count_next;       // saturated joint count
    logic [IW-1:0]             idx_reg, idx_next;
    logic [DIV_CNT_W-1:0]      div_cnt_reg, div_cnt_next;
    logic                      m_valid_reg, m_valid_next;
    logic [JN_W-1:0]           m_joint_number_reg, m_joint_number_next;
    logic signed [ANGLE_W-1:0] m_angle_reg, m_angle_next;
    logic                      m_last_reg, m_last_next;

    logic        [JC_W-1:0]    count_sat;
    logic                      idx_zero;
    logic                      last_flag;
    logic                      out_free;
    dp_ctrl_t                  dp_ctrl;
    dp_status_t                dp_status;

    hjsg_datapath #(
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .aclk   (aclk),
        .ctrl   (dp_ctrl),
        .idx    (idx_reg),
        .status (dp_status)
    );

    // joint count above MAX_JOINTS saturates
    always_comb begin
        if (int'(joint_count_reg) > MAX_JOINTS) begin
            count_sat = JC_W'(MAX_JOINTS);
        end else begin
            count_sat = JC_W'(joint_count_reg);
        end
    end

    assign idx_zero  = (idx_reg == '0);
    assign last_flag = (joint_reg == (count_reg - JC_W'(1)));
    assign out_free  = ~m_valid_reg | m_ready;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);

    always_comb begin
        state_next          = state_reg;
        joint_count_next    = joint_count_reg;
        joint_next          = joint_reg;
        count_next          = count_reg;
        idx_next            = idx_reg;
        div_cnt_next        = div_cnt_reg;
        m_joint_number_next = m_joint_number_reg;
        m_angle_next        = m_angle_reg;
        m_last_next         = m_last_reg;
        m_valid_next        = m_valid_reg & ~m_ready;
        dp_ctrl.op          = DP_IDLE;
        dp_ctrl.base_sel    = BASE_SEL_W'(joint_reg);

        if (cfg_valid && cfg_ready) begin
            joint_count_next = cfg_data;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    idx_next   = s_start_index[IW-1:0];
                    count_next = count_sat;
                    joint_next = '0;
                    if (count_sat != '0) begin
                        state_next = S_JOINT;
                    end
                end
            end
            S_JOINT: begin
                if (idx_zero) begin
                    state_next = S_EMIT;
                end else begin
                    dp_ctrl.op = DP_LOAD;
                    state_next = S_MUL;
                end
            end
            S_MUL: begin
                dp_ctrl.op = DP_MUL_DIGIT;
                state_next = S_FIX;
            end
            S_FIX: begin
                dp_ctrl.op = DP_FIX;
                state_next = S_ACC;
            end
            S_ACC: begin
                dp_ctrl.op = DP_ACC;
                if (dp_status.digits_done) begin
                    div_cnt_next = DIV_CNT_W'(FRAC_BITS - 1);
                    state_next   = S_DIV;
                end else begin
                    state_next = S_MUL;
                end
            end
            S_DIV: begin
                dp_ctrl.op   = DP_DIV_STEP;
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                if (div_cnt_reg == '0) begin
                    state_next = S_ANG_MUL;
                end
            end
            S_ANG_MUL: begin
                dp_ctrl.op = DP_MUL_ANGLE;
                state_next = S_ANG_RND;
            end
            S_ANG_RND: begin
                dp_ctrl.op = DP_ROUND;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_joint_number_next = JN_W'(joint_reg);
                    m_angle_next        = idx_zero ? '0 : dp_status.angle;
                    m_last_next         = last_flag;
                    joint_next          = joint_reg + JC_W'(1);
                    state_next          = last_flag ? S_IDLE : S_JOINT;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            joint_count_reg <= JOINT_COUNT_RESET;
            joint_reg       <= '0;
            count_reg       <= '0;
            div_cnt_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            joint_count_reg <= joint_count_next;
            joint_reg       <= joint_next;
            count_reg       <= count_next;
            div_cnt_reg     <= div_cnt_next;
            m_valid_reg     <= m_valid_next;
        end
        idx_reg            <= idx_next;
        m_joint_number_reg <= m_joint_number_next;
        m_angle_reg        <= m_angle_next;
        m_last_reg         <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_joint_number = m_joint_number_reg;
    assign m_angle        = m_angle_reg;
    assign m_last         = m_last_reg;

    // checks
    `HJSG_ASSERT_NOW(a_joint_in_range, aclk, aresetn, (state_reg != S_IDLE),
        (joint_reg < count_reg), "joint counter passed the joint count")
    `HJSG_ASSERT_NOW(a_zero_idx_no_digits, aclk, aresetn, (state_reg == S_MUL),
        (idx_reg != '0), "digit loop entered for a zero index")
    `HJSG_ASSERT_NEXT(a_emit_holds, aclk, aresetn,
        ((state_reg == S_EMIT) && m_valid && !m_ready), (state_reg == S_EMIT),
        "result register overwritten while stalled")

endmodule

>>> hdl/hjsg_datapath.sv
// Arithmetic unit: one wide multiplier, base multipliers, adders, working registers.
// Depends on hjsg_pkg; driven by the sequencer in the top level.
`timescale 1ns / 1ps

module hjsg_datapath #(
    parameter int INDEX_BITS = hjsg_pkg::INDEX_BITS_DEF
) (
    input  logic                 aclk,
    input  hjsg_pkg::dp_ctrl_t   ctrl,
    input  logic [((INDEX_BITS < hjsg_pkg::START_INDEX_W) ? INDEX_BITS
                   : hjsg_pkg::START_INDEX_W)-1:0] idx,
    output hjsg_pkg::dp_status_t status
);
    import hjsg_pkg::*;

    localparam int IW      = (INDEX_BITS < START_INDEX_W) ? INDEX_BITS : START_INDEX_W;
    localparam int DEN_W   = IW + BASE_W;
    localparam int RAW_W   = BASE_W + 1;
    localparam int MUL_A_W = (IW > FRAC_BITS) ? IW : FRAC_BITS;
    localparam int PROD_W  = MUL_A_W + RECIP_W;
    localparam logic [PROD_W-1:0] RND_HALF = PROD_W'(64'h8000_0000);

    // working registers
    logic [IW-1:0]        n_reg, n_next;          // digits left to extract
    logic [IW-1:0]        q_reg, q_next;          // quotient estimate
    logic [RAW_W-1:0]     rraw_reg, rraw_next;    // uncorrected remainder
    logic [DEN_W-1:0]     rev_reg, rev_next;      // reversed digits
    logic [DEN_W-1:0]     den_reg, den_next;      // base^k
    logic [DEN_W-1:0]     rem_reg, rem_next;      // divider remainder
    logic [FRAC_BITS-1:0] inv_reg, inv_next;      // Q0.16 radical inverse
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic                 neg_reg, neg_next;
    logic [ANGLE_W-1:0]   angle_reg, angle_next;

    logic [BASE_W-1:0]        base;
    logic [RECIP_W-1:0]       recip;
    logic [MUL_A_W-1:0]       mul_a;
    logic [RECIP_W-1:0]       mul_b;
    logic [PROD_W-1:0]        mul_p;
    logic [FRAC_BITS-1:0]     mag_in;
    logic [IW-1:0]            q_est;
    logic [IW+BASE_W-1:0]     qb;
    logic [IW+BASE_W-1:0]     diff;
    logic                     corr;
    logic [BASE_W-1:0]        digit;
    logic [IW-1:0]            q_fix;
    logic [DEN_W+BASE_W-1:0]  rev_mul;
    logic [DEN_W+BASE_W-1:0]  den_mul;
    logic [DEN_W-1:0]         rev_acc;
    logic [DEN_W:0]           rem2;
    logic [DEN_W:0]           rem_diff;
    logic                     ge;
    logic [PROD_W-1:0]        rnd_sum;
    logic [ANGLE_W-1:0]       mag;

    assign base  = prime_base(ctrl.base_sel);
    assign recip = recip_q32(ctrl.base_sel);

    // |inverse - 0.5| in Q0.16
    assign mag_in = inv_reg[FRAC_BITS-1] ? (inv_reg - HALF_Q0_16) : (HALF_Q0_16 - inv_reg);

    // the shared multiplier
    assign mul_a = (ctrl.op == DP_MUL_ANGLE) ? MUL_A_W'(mag_in) : MUL_A_W'(n_reg);
    assign mul_b = (ctrl.op == DP_MUL_ANGLE) ? TWO_PI_Q3_28 : recip;
    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // digit extraction
    assign q_est = prod_reg[RECIP_SHIFT +: IW];
    assign qb    = (IW+BASE_W)'(q_est) * (IW+BASE_W)'(base);
    assign diff  = (IW+BASE_W)'(n_reg) - qb;

    assign corr    = (rraw_reg >= RAW_W'(base));
    assign digit   = corr ? BASE_W'(rraw_reg - RAW_W'(base)) : BASE_W'(rraw_reg);
    assign q_fix   = q_reg + IW'(corr);
    assign rev_mul = (DEN_W+BASE_W)'(rev_reg) * (DEN_W+BASE_W)'(base);
    assign den_mul = (DEN_W+BASE_W)'(den_reg) * (DEN_W+BASE_W)'(base);
    assign rev_acc = rev_mul[DEN_W-1:0] + DEN_W'(digit);

    // restoring fraction divider step
    assign rem2     = {rem_reg, 1'b0};
    assign rem_diff = rem2 - {1'b0, den_reg};
    assign ge       = (rem2 >= {1'b0, den_reg});

    // round half away from zero on the magnitude
    assign rnd_sum = prod_reg + RND_HALF;
    assign mag     = rnd_sum[RECIP_SHIFT +: ANGLE_W];

    always_comb begin
        n_next     = n_reg;
        q_next     = q_reg;
        rraw_next  = rraw_reg;
        rev_next   = rev_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        inv_next   = inv_reg;
        prod_next  = prod_reg;
        neg_next   = neg_reg;
        angle_next = angle_reg;
        case (ctrl.op)
            DP_LOAD: begin
                n_next   = idx;
                rev_next = '0;
                den_next = DEN_W'(1);
            end
            DP_MUL_DIGIT: begin
                prod_next = mul_p;
            end
            DP_FIX: begin
                q_next    = q_est;
                rraw_next = diff[RAW_W-1:0];
            end
            DP_ACC: begin
                n_next   = q_fix;
                rev_next = rev_acc;
                den_next = den_mul[DEN_W-1:0];
                rem_next = rev_acc;
            end
            DP_DIV_STEP: begin
                rem_next = ge ? rem_diff[DEN_W-1:0] : rem2[DEN_W-1:0];
                inv_next = {inv_reg[FRAC_BITS-2:0], ge};
            end
            DP_MUL_ANGLE: begin
                prod_next = mul_p;
                neg_next  = ~inv_reg[FRAC_BITS-1];
            end
            DP_ROUND: begin
                angle_next = neg_reg ? (ANGLE_W'(0) - mag) : mag;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        n_reg     <= n_next;
        q_reg     <= q_next;
        rraw_reg  <= rraw_next;
        rev_reg   <= rev_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        inv_reg   <= inv_next;
        prod_reg  <= prod_next;
        neg_reg   <= neg_next;
        angle_reg <= angle_next;
    end

    assign status.digits_done = (q_fix == '0);
    assign status.angle       = $signed(angle_reg);

endmodule
